// ----- hdl/lcgr_pkg.sv -----
// Package for the LCG random range generator: field widths, generator
// constants, register indexes and the controller state type.
// No dependencies.
`default_nettype none

package lcgr_pkg;

   localparam int STATE_W   = 32;
   localparam int FUNC_W    = 1;
   localparam int MOD_W     = 32;
   localparam int INT_W     = 15;
   localparam int FRAC_W    = 30;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int DIGIT_W   = 4;
   localparam int STEP_CNT_W = 3;

   localparam logic [STATE_W-1:0] LCG_MUL = 32'd1103515245;
   localparam logic [STATE_W-1:0] LCG_ADD = 32'd12345;
   localparam logic [15:0]        DRAW_MOD = 16'h7FFF;

   localparam logic [STEP_CNT_W-1:0] LAST_STEP = 3'd7;

   localparam logic [FUNC_W-1:0] FUNC_INT  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FRAC = 1'b1;

   localparam logic [CSR_ADDR_W-3:0] REG_SEED = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

endpackage

`default_nettype wire

// ----- hdl/lcgr_channels.sv -----
// Valid/ready channel interfaces for draw requests and draw results.
// Depends on lcgr_pkg.
`default_nettype none

interface lcgr_req_if;
   import lcgr_pkg::*;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [MOD_W-1:0]    modulus;
   modport source (output valid, func, modulus, input ready);
   modport sink   (input valid, func, modulus, output ready);
endinterface

interface lcgr_rsp_if;
   import lcgr_pkg::*;
   logic                valid;
   logic                ready;
   logic [INT_W-1:0]    int_value;
   logic [FRAC_W-1:0]   fraction;
   modport source (output valid, int_value, fraction, input ready);
   modport sink   (input valid, int_value, fraction, output ready);
endinterface

`default_nettype wire

// ----- hdl/lcg_random_range_generator_unit.sv -----
// LCG random range generator, top level.
// Depends on lcgr_pkg and the channel interfaces in lcgr_channels.sv.
//
// Usage: a request transaction on req_ch carries func and modulus. Each one
// yields exactly one result transaction on rsp_ch. func = 0 gives
// int_value = r mod modulus (fraction 0); func = 1 gives fraction = r*32769
// as Q0.30 (int_value 0). An integer draw with modulus 0 returns 0 and does
// not advance the generator.
// Steps: the state update is a radix-16 shift-add multiply; the draw fold
// follows; the modulo is a radix-4 restoring divider; the result register
// loads last. Fraction draws skip the divider and zero-modulus draws go
// straight to the result register. A new request is taken only in idle, once
// the previous draw has moved into the result register.
// The result register decouples the sides: the next request is accepted while
// a result waits; a finished draw waits in its last step while rsp_ch stalls.
// Reset (synchronous) clears the seed and the generator state to 0 and empties
// the result register. Writing the seed register at address 0 loads the state.
`default_nettype none

module lcg_random_range_generator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lcgr_req_if.sink                           req_ch,
   lcgr_rsp_if.source                         rsp_ch,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lcgr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [lcgr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [lcgr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);
   import lcgr_pkg::*;

   ctrl_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [STATE_W-1:0]      lcg_state_ff, lcg_state_in;
   logic [STATE_W-1:0]      seed_ff, seed_in;
   logic [STATE_W-1:0]      acc_ff, acc_in;
   logic [STATE_W-1:0]      mcand_ff, mcand_in;
   logic [STATE_W-1:0]      sh_ff, sh_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [15:0]             n_lo_ff, n_lo_in;
   logic                    n_big_ff, n_big_in;
   logic [15:0]             rem_ff, rem_in;
   logic [15:0]             dvd_ff, dvd_in;
   logic [INT_W-1:0]        res_int_ff, res_int_in;
   logic [FRAC_W-1:0]       res_frac_ff, res_frac_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INT_W-1:0]        rsp_int_ff, rsp_int_in;
   logic [FRAC_W-1:0]       rsp_frac_ff, rsp_frac_in;

   logic                    req_take;
   logic                    csr_wr;
   logic [STATE_W+DIGIT_W-1:0] prod;
   logic [15:0]             fold_t, fold_r;
   logic [15:0]             t1, t2, rem1, rem2;
   logic                    ge1, ge2;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_SEED) ? seed_ff : '0;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1:2] == REG_SEED);

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign req_take        = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.int_value = rsp_int_ff;
   assign rsp_ch.fraction = rsp_frac_ff;

   // one digit of the state times the shifted multiplier
   assign prod = {{DIGIT_W{1'b0}}, mcand_ff} * {{STATE_W{1'b0}}, sh_ff[DIGIT_W-1:0]};

   // (state >> 16) mod (2^15 - 1) by end-around fold
   assign fold_t = {1'b0, lcg_state_ff[30:16]} + {15'b0, lcg_state_ff[31]};
   assign fold_r = (fold_t >= DRAW_MOD) ? (fold_t - DRAW_MOD) : fold_t;

   // two restoring divider steps
   assign t1   = {rem_ff[14:0], dvd_ff[15]};
   assign ge1  = !n_big_ff && (t1 >= n_lo_ff);
   assign rem1 = ge1 ? (t1 - n_lo_ff) : t1;
   assign t2   = {rem1[14:0], dvd_ff[14]};
   assign ge2  = !n_big_ff && (t2 >= n_lo_ff);
   assign rem2 = ge2 ? (t2 - n_lo_ff) : t2;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lcg_state_in = lcg_state_ff;
      seed_in      = seed_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      sh_in        = sh_ff;
      func_in      = func_ff;
      n_lo_in      = n_lo_ff;
      n_big_in     = n_big_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      res_int_in   = res_int_ff;
      res_frac_in  = res_frac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_int_in   = rsp_int_ff;
      rsp_frac_in  = rsp_frac_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_ch.func;
               n_lo_in  = req_ch.modulus[15:0];
               n_big_in = |req_ch.modulus[MOD_W-1:16];
               if (req_ch.func == FUNC_INT && req_ch.modulus == '0) begin
                  res_int_in  = '0;
                  res_frac_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  acc_in   = LCG_ADD;
                  mcand_in = LCG_MUL;
                  sh_in    = lcg_state_ff;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            acc_in   = acc_ff + prod[STATE_W-1:0];
            mcand_in = {mcand_ff[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            sh_in    = {{DIGIT_W{1'b0}}, sh_ff[STATE_W-1:DIGIT_W]};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               lcg_state_in = acc_in;
               state_in     = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (func_ff == FUNC_FRAC) begin
               // r*32769 = (r << 15) + r, no overlap since r < 2^15
               res_frac_in = {fold_r[14:0], fold_r[14:0]};
               res_int_in  = '0;
               state_in    = ST_DONE;
            end else begin
               dvd_in   = {1'b0, fold_r[14:0]};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem2;
            dvd_in = {dvd_ff[13:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               res_int_in  = rem2[INT_W-1:0];
               res_frac_in = '0;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = res_int_ff;
               rsp_frac_in  = res_frac_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         seed_in      = pwdata;
         lcg_state_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         lcg_state_ff <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lcg_state_ff <= lcg_state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      sh_ff       <= sh_in;
      func_ff     <= func_in;
      n_lo_ff     <= n_lo_in;
      n_big_ff    <= n_big_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      res_int_ff  <= res_int_in;
      res_frac_ff <= res_frac_in;
      rsp_int_ff  <= rsp_int_in;
      rsp_frac_ff <= rsp_frac_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != ST_IDLE)
      else $error("request accepted but controller stayed idle");

   a_rem_below_modulus: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && !n_big_ff |-> rem_ff < n_lo_ff)
      else $error("partial remainder not below modulus");

   a_one_field_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_int_ff == '0 || rsp_frac_ff == '0))
      else $error("both result fields nonzero");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready) |=> rsp_valid_ff)
      else $error("finished draw not delivered to result register");

endmodule

`default_nettype wire
